/* rtl/pmp2d_pkg.sv */
// Package for the padded 2-D max pooling block.
// Holds register indexes, field widths and shared types; depends on nothing.
`default_nettype none
package pmp2d_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_IMG_WIDTH   = 3'd0;
    localparam logic [2:0] REG_IMG_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_KERNEL_SIZE = 3'd2;
    localparam logic [2:0] REG_STRIDE      = 3'd3;
    localparam logic [2:0] REG_PADDING     = 3'd4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int PIX_W      = 16;
    localparam int ROW_W      = 13;
    localparam int COL_W      = 11;
    localparam int RESULT_CAP = 64;

    typedef logic signed [PIX_W-1:0] t_pix;
    typedef logic [ROW_W-1:0]        t_row;
    typedef logic [COL_W-1:0]        t_col;
    typedef logic signed [14:0]      t_ycoord;   // emission row coordinate
    typedef logic signed [12:0]      t_xcoord;   // emission column coordinate

endpackage
`default_nettype wire

/* rtl/padded_max_pool_2d.sv */
// Top level of the padded 2-D max pooling block: line store and sequencer.
// Depends on pmp2d_pkg.
//
//  channel  direction  handshake           payload
//  input    in         i_valid / o_ready   i_pixel, i_frame_start
//  output   out        o_valid / i_ready   o_pooled, o_out_row, o_out_col, o_last_of_run
//  config   in         i_cfg_we            i_cfg_index, i_cfg_wdata
//
// Each pixel is accepted, the column and row due scans then check one window index at a
// time, each emitted window takes a setup step, one store read per window pixel (up to
// K*K through the single read port), a drain step and an output step; a finish step ends.
// An empty window skips the reads and the drain step.
// Reset is synchronous, active low; the line store is not cleared.
// The output holds while i_ready is low; the block takes no pixel until a transaction ends.
`default_nettype none
module padded_max_pool_2d
    import pmp2d_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_KERNEL = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic signed [15:0]    i_pixel,
    input  wire logic                  i_frame_start,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic signed [15:0]         o_pooled,
    output logic [12:0]                o_out_row,
    output logic [10:0]                o_out_col,
    output logic                       o_last_of_run,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int SW    = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int DEPTH = MAX_KERNEL * (2 ** AW);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_XSCAN = 4'd1;
    localparam logic [3:0] S_YSCAN = 4'd2;
    localparam logic [3:0] S_SETUP = 4'd3;
    localparam logic [3:0] S_READ  = 4'd4;
    localparam logic [3:0] S_DRAIN = 4'd5;
    localparam logic [3:0] S_OUT   = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;

    localparam logic [SW:0]   MK_V   = (SW+1)'(MAX_KERNEL);
    localparam logic [SW-1:0] MK_TOP = SW'(MAX_KERNEL - 1);
    localparam logic [10:0]   MW_V   = 11'((MAX_WIDTH > 2047) ? 2047 : MAX_WIDTH);
    localparam logic [3:0]    MKER_V = 4'(MAX_KERNEL);

    // configuration registers
    logic [10:0] r_img_width;
    logic [12:0] r_img_height;
    logic [3:0]  r_kernel;
    logic [3:0]  r_stride;
    logic [2:0]  r_padding;

    // control state
    logic [3:0]    r_state;
    t_row          r_row;
    t_col          r_col;
    logic          r_done;
    logic [SW-1:0] r_rslot;
    t_row          r_pr;
    t_col          r_pc;

    // due window pointers and scan registers
    t_col    r_xlo, r_xend, r_sx;
    t_xcoord r_exlo, r_exend, r_sex;
    t_row    r_ylo, r_yend, r_sy;
    t_ycoord r_eylo, r_eyend, r_sey;

    // window walk
    t_row    r_oy;
    t_col    r_ox;
    t_ycoord r_ey;
    t_xcoord r_ex;
    logic [6:0] r_cnt;
    t_row    r_y, r_y1;
    t_col    r_x, r_x0, r_x1;
    logic [SW-1:0] r_slot;
    logic    r_last;

    // store read and max
    logic signed [15:0] r_mem [0:DEPTH-1];
    t_pix    r_rd_data;
    logic    r_rd_vld;
    t_pix    r_best;
    logic    r_have;

    // derived settings
    logic [10:0] w_eff;
    logic [3:0]  k_eff;
    t_xcoord     lim_x, wm1_x, c_x;
    t_ycoord     lim_y, hm1_y, r_y_s;
    t_ycoord     e0_y;
    t_xcoord     e0_x;
    logic        c_last;
    logic        x_due, y_due;

    always_comb begin
        w_eff  = (r_img_width > MW_V) ? MW_V : r_img_width;
        k_eff  = (r_kernel > MKER_V) ? MKER_V : r_kernel;
        wm1_x  = $signed({2'b00, w_eff}) - 13'sd1;
        lim_x  = wm1_x + $signed({10'd0, r_padding});
        hm1_y  = $signed({2'b00, r_img_height}) - 15'sd1;
        lim_y  = hm1_y + $signed({12'd0, r_padding});
        e0_y   = $signed({11'd0, k_eff}) - 15'sd1 - $signed({12'd0, r_padding});
        e0_x   = 13'(e0_y);
        c_x    = $signed({2'b00, r_pc});
        r_y_s  = $signed({2'b00, r_pr});
        c_last = (c_x == wm1_x);
        x_due  = (r_sex <= lim_x) && ((r_sex <= c_x) || c_last);
        y_due  = (r_sey <= lim_y) && ((r_sey <= r_y_s) || (r_y_s == hm1_y));
    end

    // window bounds for the setup step
    t_ycoord wy0s, wy0c, wy1s;
    t_xcoord wx0s, wx0c, wx1s;
    logic    ypad, wempty;
    t_row    dd;
    logic [SW:0] d_s, slot_w;

    always_comb begin
        wy0s   = r_ey - $signed({11'd0, k_eff}) + 15'sd1;
        wy0c   = (wy0s < 0) ? 15'sd0 : wy0s;
        wy1s   = (r_ey > hm1_y) ? hm1_y : r_ey;
        wx0s   = r_ex - $signed({9'd0, k_eff}) + 13'sd1;
        wx0c   = (wx0s < 0) ? 13'sd0 : wx0s;
        wx1s   = (r_ex > wm1_x) ? wm1_x : r_ex;
        ypad   = (wy0s < 0) || (r_ey > hm1_y);
        wempty = (wy1s < wy0c) || (wx1s < wx0c);
        dd     = r_pr - 13'(wy0c);
        d_s    = (SW+1)'(dd);
        slot_w = ({1'b0, r_rslot} >= d_s) ? ({1'b0, r_rslot} - d_s)
                                          : ({1'b0, r_rslot} + MK_V - d_s);
    end

    // handshake outputs
    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_pooled      = r_best;
    assign o_out_row     = r_oy;
    assign o_out_col     = r_ox;
    assign o_last_of_run = r_last;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_width  <= 11'd1024;
            r_img_height <= 13'd1024;
            r_kernel     <= 4'd2;
            r_stride     <= 4'd2;
            r_padding    <= 3'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_IMG_WIDTH:   r_img_width  <= i_cfg_wdata[10:0];
                REG_IMG_HEIGHT:  r_img_height <= i_cfg_wdata;
                REG_KERNEL_SIZE: r_kernel     <= i_cfg_wdata[3:0];
                REG_STRIDE:      r_stride     <= i_cfg_wdata[3:0];
                REG_PADDING:     r_padding    <= i_cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    // line store write and read port
    logic         mem_we, acc;
    logic [SW+AW-1:0] wr_addr, rd_addr;
    t_row         row_e;
    t_col         col_e;
    logic         done_e;
    logic         pos0;

    always_comb begin
        acc     = i_valid && o_ready;
        row_e   = i_frame_start ? '0 : r_row;
        col_e   = i_frame_start ? '0 : r_col;
        done_e  = i_frame_start ? 1'b0 : r_done;
        // first pixel of a plane: scans start from the current settings
        pos0    = i_frame_start || (r_row == '0 && r_col == '0);
        mem_we  = acc && (w_eff != 0) && (r_img_height != 0) && !done_e
                  && (row_e < r_img_height) && (col_e < w_eff);
        wr_addr = {(i_frame_start ? {SW{1'b0}} : r_rslot), AW'(col_e)};
        rd_addr = {r_slot, AW'(r_x)};
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= i_pixel;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // sequencer
    logic [13:0] row_nx;
    assign row_nx = {1'b0, r_pr} + 14'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_row    <= '0;
            r_col    <= '0;
            r_done   <= 1'b0;
            r_rslot  <= '0;
            r_xlo    <= '0;
            r_ylo    <= '0;
            r_exlo   <= 13'sd1;
            r_eylo   <= 15'sd1;
            r_rd_vld <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_rd_vld <= (r_state == S_READ);
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        if (i_frame_start) begin
                            r_row   <= '0;
                            r_col   <= '0;
                            r_done  <= 1'b0;
                            r_rslot <= '0;
                            r_xlo   <= '0;
                            r_ylo   <= '0;
                            r_exlo  <= e0_x;
                            r_eylo  <= e0_y;
                        end
                        r_sx    <= pos0 ? '0 : r_xlo;
                        r_sex   <= pos0 ? e0_x : r_exlo;
                        r_sy    <= pos0 ? '0 : r_ylo;
                        r_sey   <= pos0 ? e0_y : r_eylo;
                        r_xend  <= pos0 ? '0 : r_xlo;
                        r_exend <= pos0 ? e0_x : r_exlo;
                        r_yend  <= pos0 ? '0 : r_ylo;
                        r_eyend <= pos0 ? e0_y : r_eylo;
                        r_pr    <= row_e;
                        r_pc    <= col_e;
                        if (w_eff != 0 && r_img_height != 0) begin
                            if (!mem_we) begin
                                r_done <= 1'b1;
                            end else if (k_eff == 0 || r_stride == 0) begin
                                r_state <= S_FIN;
                            end else begin
                                r_state <= S_XSCAN;
                            end
                        end
                    end
                end
                // find the end of the due column range
                S_XSCAN: begin
                    if (x_due) begin
                        r_sx  <= r_sx + 11'd1;
                        r_sex <= r_sex + $signed({9'd0, r_stride});
                    end else begin
                        r_xend  <= r_sx;
                        r_exend <= r_sex;
                        r_state <= S_YSCAN;
                    end
                end
                // find the end of the due row range
                S_YSCAN: begin
                    if (y_due) begin
                        r_sy  <= r_sy + 13'd1;
                        r_sey <= r_sey + $signed({11'd0, r_stride});
                    end else begin
                        r_yend  <= r_sy;
                        r_eyend <= r_sey;
                        r_oy    <= r_ylo;
                        r_ey    <= r_eylo;
                        r_ox    <= r_xlo;
                        r_ex    <= r_exlo;
                        r_cnt   <= '0;
                        r_state <= (r_ylo < r_sy && r_xlo < r_xend) ? S_SETUP : S_FIN;
                    end
                end
                S_SETUP: begin
                    r_y    <= 13'(wy0c);
                    r_y1   <= 13'(wy1s);
                    r_x    <= 11'(wx0c);
                    r_x0   <= 11'(wx0c);
                    r_x1   <= 11'(wx1s);
                    r_slot <= SW'(slot_w);
                    r_last <= (r_cnt == 7'(RESULT_CAP - 1))
                              || ((r_oy + 13'd1 == r_yend) && (r_ox + 11'd1 == r_xend));
                    r_state <= wempty ? S_OUT : S_READ;
                end
                // one store read per cycle over the window
                S_READ: begin
                    if (r_x == r_x1) begin
                        if (r_y == r_y1) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_y    <= r_y + 13'd1;
                            r_x    <= r_x0;
                            r_slot <= (r_slot == MK_TOP) ? '0 : r_slot + SW'(1);
                        end
                    end else begin
                        r_x <= r_x + 11'd1;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_cnt <= r_cnt + 7'd1;
                        if (r_last) begin
                            r_state <= S_FIN;
                        end else begin
                            if (r_ox + 11'd1 < r_xend) begin
                                r_ox <= r_ox + 11'd1;
                                r_ex <= r_ex + $signed({9'd0, r_stride});
                            end else begin
                                r_ox <= r_xlo;
                                r_ex <= r_exlo;
                                r_oy <= r_oy + 13'd1;
                                r_ey <= r_ey + $signed({11'd0, r_stride});
                            end
                            r_state <= S_SETUP;
                        end
                    end
                end
                // advance position and due pointers
                S_FIN: begin
                    if (c_last) begin
                        r_col  <= '0;
                        r_xlo  <= '0;
                        r_exlo <= e0_x;
                        r_ylo  <= r_yend;
                        r_eylo <= r_eyend;
                        if (row_nx >= {1'b0, r_img_height}) begin
                            r_row   <= '0;
                            r_rslot <= '0;
                            r_done  <= 1'b1;
                        end else begin
                            r_row   <= 13'(row_nx);
                            r_rslot <= (r_rslot == MK_TOP) ? '0 : r_rslot + SW'(1);
                        end
                    end else begin
                        r_col  <= r_pc + 11'd1;
                        r_xlo  <= r_xend;
                        r_exlo <= r_exend;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // running maximum; padding rows seed it with zero
    always_ff @(posedge i_clk) begin
        if (r_state == S_SETUP) begin
            r_best <= '0;
            r_have <= ypad;
        end else if (r_rd_vld) begin
            if (!r_have || r_rd_data > r_best) begin
                r_best <= r_rd_data;
            end
            r_have <= 1'b1;
        end
    end

endmodule
`default_nettype wire

/* rtl/pmp2d_checker.sv */
// Port-level checks for padded_max_pool_2d, with the bind that attaches them.
// Depends on pmp2d_pkg and on the top level's port names.
`default_nettype none
module pmp2d_checker
    import pmp2d_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire t_pix        o_pooled,
    input wire logic [10:0] o_out_col
);

    // a pending result holds until its transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pooled) && $stable(o_out_col))
        else $error("result changed while stalled");

    // no pixel is taken while a result is shown
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input ready while result pending");

    // a taken result is never followed directly by another
    a_out_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready |=> !o_valid)
        else $error("result directly after a taken result");

    // a result never appears right after an accept
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_valid)
        else $error("result in the cycle after accept");

endmodule

bind padded_max_pool_2d pmp2d_checker u_pmp2d_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (i_valid),
    .o_ready   (o_ready),
    .o_valid   (o_valid),
    .i_ready   (i_ready),
    .o_pooled  (o_pooled),
    .o_out_col (o_out_col)
);
`default_nettype wire
